// ===== rtl/fekv_pkg.sv =====
// Shared types and constants for the FIFO-evicting key/value cache.
package fekv_pkg;

  localparam int KEY_BITS   = 64;
  localparam int WORD_BITS  = 64;
  localparam int LIMIT_BITS = 9;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 9'd256;

  // Request codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MISS     = 2'd0,
    ST_HIT      = 2'd1,
    ST_INSERTED = 2'd2,
    ST_PRESENT  = 2'd3
  } status_e;

endpackage

// ===== rtl/fekv_store.sv =====
// Key and payload storage: one write port, one registered read port.
module fekv_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int PB    = 64
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [fekv_pkg::KEY_BITS-1:0] rd_key_o,
  output logic [PB-1:0]                 rd_pay_o,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [fekv_pkg::KEY_BITS-1:0] wr_key_i,
  input  logic [PB-1:0]                 wr_pay_i
);
  import fekv_pkg::*;

  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [PB-1:0]       pay_mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      pay_mem[wr_addr_i] <= wr_pay_i;
    end
  end

  // Read one entry into registered outputs
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
      rd_pay_o <= pay_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/fekv_seq.sv =====
// Request sequencer: trim, sequential key scan, append, result register.
module fekv_seq #(
  parameter int CAPACITY = 256,
  parameter int PB       = 64,
  parameter int CW       = 9,
  parameter int PW       = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [CW-1:0]                  lim_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           req_type_i,
  input  logic [fekv_pkg::KEY_BITS-1:0]  key_i,
  input  logic [fekv_pkg::WORD_BITS-1:0] payload_in_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [fekv_pkg::WORD_BITS-1:0] payload_out_o,
  output logic                           rd_en_o,
  output logic [PW-1:0]                  rd_addr_o,
  input  logic [fekv_pkg::KEY_BITS-1:0]  rd_key_i,
  input  logic [PB-1:0]                  rd_pay_i,
  output logic                           wr_en_o,
  output logic [PW-1:0]                  wr_addr_o,
  output logic [fekv_pkg::KEY_BITS-1:0]  wr_key_o,
  output logic [PB-1:0]                  wr_pay_o
);
  import fekv_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TRIM   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;

  localparam logic [CW:0] CAP_W = (CW+1)'(CAPACITY);

  logic [2:0]          state_q, state_d;
  logic [PW-1:0]       oldest_q, oldest_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                rd_v_q, rd_v_d;
  logic                req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [PB-1:0]       pay_q;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [PB-1:0]       pout_q, pout_d;

  // Shared modular pointer adder
  logic [PW-1:0] add_a;
  logic [CW-1:0] add_b;
  logic [CW:0]   add_raw;
  logic [PW-1:0] add_sum;

  logic accept;
  logic hit;
  logic issue;
  logic over;

  assign accept  = start_i && (state_q == S_IDLE);
  assign over    = count_q > lim_i;
  assign hit     = rd_v_q && (rd_key_i == key_q);
  assign issue   = (state_q == S_SCAN) && (idx_q < count_q) && !hit;

  assign add_raw = (CW+1)'(add_a) + (CW+1)'(add_b);
  assign add_sum = (add_raw >= CAP_W) ? PW'(add_raw - CAP_W) : PW'(add_raw);

  // Select adder operands by step
  always_comb begin
    add_a = oldest_q;
    add_b = '0;
    unique case (state_q)
      S_TRIM:   add_b = over ? (count_q - lim_i) : '0;
      S_SCAN: begin
        add_a = rd_ptr_q;
        add_b = CW'(1);
      end
      S_APPEND: add_b = (count_q >= lim_i) ? CW'(1) : count_q;
      default:  add_b = '0;
    endcase
  end

  // Sequence one request
  always_comb begin
    state_d  = state_q;
    oldest_d = oldest_q;
    count_d  = count_q;
    idx_d    = idx_q;
    rd_ptr_d = rd_ptr_q;
    rd_v_d   = 1'b0;
    done_d   = 1'b0;
    status_d = status_q;
    pout_d   = pout_q;
    wr_en_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_TRIM;
      end
      S_TRIM: begin
        // drop oldest entries until the count fits the limit
        oldest_d = add_sum;
        rd_ptr_d = add_sum;
        if (over) count_d = lim_i;
        idx_d    = '0;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        rd_v_d = issue;
        if (issue) begin
          rd_ptr_d = add_sum;
          idx_d    = idx_q + CW'(1);
        end
        if (hit) begin
          done_d   = 1'b1;
          status_d = (req_q == REQ_INSERT) ? ST_PRESENT : ST_HIT;
          pout_d   = (req_q == REQ_INSERT) ? '0 : rd_pay_i;
          state_d  = S_IDLE;
        end else if (!issue && !rd_v_q) begin
          if (req_q == REQ_LOOKUP) begin
            done_d   = 1'b1;
            status_d = ST_MISS;
            pout_d   = '0;
            state_d  = S_IDLE;
          end else if (lim_i == '0) begin
            done_d   = 1'b1;
            status_d = ST_INSERTED;
            pout_d   = '0;
            state_d  = S_IDLE;
          end else begin
            state_d = S_APPEND;
          end
        end
      end
      S_APPEND: begin
        if (count_q >= lim_i) begin
          // evict oldest to make room
          oldest_d = add_sum;
          count_d  = count_q - CW'(1);
        end else begin
          wr_en_o  = 1'b1;
          count_d  = count_q + CW'(1);
          done_d   = 1'b1;
          status_d = ST_INSERTED;
          pout_d   = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      oldest_q <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      rd_ptr_q <= '0;
      rd_v_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_ptr_q <= rd_ptr_d;
      rd_v_q   <= rd_v_d;
      done_q   <= done_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      key_q <= key_i;
      pay_q <= payload_in_i[PB-1:0];
    end
    status_q <= status_d;
    pout_q   <= pout_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign payload_out_o = WORD_BITS'(pout_q);
  assign rd_en_o       = issue;
  assign rd_addr_o     = rd_ptr_q;
  assign wr_addr_o     = add_sum;
  assign wr_key_o      = key_q;
  assign wr_pay_o      = pay_q;

  // Live count never exceeds the store
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("entry count above capacity");

  // A result beat lasts one cycle and leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE) && !$past(done_q))
    else $error("result beat not followed by idle");

  // Trim leaves the count within the limit for scan and append
  a_trimmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_APPEND) |-> count_q <= lim_i)
    else $error("count above limit after trim");

  // Scan never issues past the live window
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> idx_q <= count_q)
    else $error("scan index past live entries");

endmodule

// ===== rtl/fifo_evicting_key_value_cache.sv =====
// Top level of the FIFO-evicting key/value cache.
//
// Fully associative cache of CAPACITY entries, each a 64-bit key and a
// PAYLOAD_BITS payload word, replaced in insertion order.
// Request channel: a beat is taken at a clock edge with start_i high and
// busy_o low; req_type_i selects lookup (0) or insert (1).
// Result channel: done_o pulses for one cycle with status_o (0 miss, 1 hit,
// 2 inserted, 3 already present) and payload_out_o (stored word on hit,
// zero otherwise). The receiver cannot stall; every result is taken.
// Scan: the keys are read from the store one per cycle through a single read
// port and one comparator; an insert that appends adds an append step, with
// an evict step first if it also evicts; busy_o is high until the result.
// Configuration: cfg_we_i writes the capacity limit (saturated at CAPACITY);
// the user writes it only while idle, which is not enforced; entries beyond
// the limit are dropped when the next request starts.
// Reset: the cache comes up empty with the limit at 256; no clearing pass.
module fifo_evicting_key_value_cache #(
  parameter int CAPACITY     = 256,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fekv_pkg::LIMIT_BITS-1:0]  cfg_wdata_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             req_type_i,
  input  logic [fekv_pkg::KEY_BITS-1:0]    key_i,
  input  logic [fekv_pkg::WORD_BITS-1:0]   payload_in_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [fekv_pkg::WORD_BITS-1:0]   payload_out_o
);
  import fekv_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  logic [LIMIT_BITS-1:0] cap_q;
  logic [LW-1:0]         cap_ext;
  logic [CW-1:0]         lim;

  logic                rd_en;
  logic [PW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  // Hold the capacity limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Saturate the limit at the store size
  assign cap_ext = LW'(cap_q);
  assign lim     = (cap_ext > LW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_ext);

  fekv_store #(
    .DEPTH (CAPACITY),
    .AW    (PW),
    .PB    (PAYLOAD_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_pay_o  (rd_pay),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_pay_i  (wr_pay)
  );

  fekv_seq #(
    .CAPACITY (CAPACITY),
    .PB       (PAYLOAD_BITS),
    .CW       (CW),
    .PW       (PW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lim_i         (lim),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .payload_in_i  (payload_in_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .payload_out_o (payload_out_o),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_key_i      (rd_key),
    .rd_pay_i      (rd_pay),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_key_o      (wr_key),
    .wr_pay_o      (wr_pay)
  );

endmodule

// ===== verif/fifo_evicting_key_value_cache_tb.sv =====
// Self-checking testbench for the FIFO-evicting key/value cache.
module fifo_evicting_key_value_cache_tb;
  import fekv_pkg::*;

  localparam int CAPACITY     = 256;
  localparam int PAYLOAD_BITS = 64;
  localparam logic [WORD_BITS-1:0] WORD_MASK = {WORD_BITS{1'b1}} >> (64 - PAYLOAD_BITS);
  localparam int POOL_SIZE    = 512;
  localparam int MAX_GAP      = 18;
  localparam int PEND_DEPTH   = 4;
  localparam int MAX_PROBES   = 32;
  // Longest quiet stretch: a full scan plus the longest sender gap, taken four times
  localparam int QUIET_LIMIT  = 4 * (CAPACITY + 8 + MAX_GAP);

  typedef struct {
    status_e              status;
    logic [WORD_BITS-1:0] word;
  } result_t;

  typedef struct {
    logic                 req;
    logic [KEY_BITS-1:0]  key;
    logic [WORD_BITS-1:0] word;
    bit                   fixed;
    result_t              res;
  } probe_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [LIMIT_BITS-1:0]  cfg_wdata_i  = '0;
  logic                   start_i      = 1'b0;
  logic                   req_type_i   = 1'b0;
  logic [KEY_BITS-1:0]    key_i        = '0;
  logic [WORD_BITS-1:0]   payload_in_i = '0;
  logic                   busy_o;
  logic                   done_o;
  logic [1:0]             status_o;
  logic [WORD_BITS-1:0]   payload_out_o;

  // Cache shadow: circular store, oldest slot, live count, limit register
  logic [KEY_BITS-1:0]    key_store  [CAPACITY];
  logic [WORD_BITS-1:0]   word_store [CAPACITY];
  int                     head_slot;
  int                     live_count;
  logic [LIMIT_BITS-1:0]  limit_reg;

  // Expected results in flight, kept as a small ring
  result_t                pend_buf[PEND_DEPTH];
  int                     pend_wr = 0;
  int                     pend_rd = 0;
  result_t                oldest_want;
  probe_t                 probe_rows[MAX_PROBES];
  int                     probe_count = 0;
  logic [KEY_BITS-1:0]    key_pool[POOL_SIZE];
  int                     mismatches;
  int                     quiet_cycles = 0;
  int                     calm_left;

  fifo_evicting_key_value_cache #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .payload_in_i  (payload_in_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .payload_out_o (payload_out_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int live_limit();
    return (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
  endfunction

  function automatic int pending_count();
    return pend_wr - pend_rd;
  endfunction

  // Apply one request to the shadow cache and return its result
  function automatic result_t lookup_or_insert(input logic req, input logic [KEY_BITS-1:0] key,
                                               input logic [WORD_BITS-1:0] word);
    result_t res;
    int      lim;
    int      slot;
    bit      found;
    lim   = live_limit();
    found = 1'b0;
    slot  = 0;
    res.word = '0;
    // Drop the oldest entries until the count fits the limit
    while (live_count > lim) begin
      head_slot = (head_slot + 1) % CAPACITY;
      live_count--;
    end
    for (int i = 0; i < live_count; i++) begin
      if (!found && key_store[(head_slot + i) % CAPACITY] == key) begin
        found = 1'b1;
        slot  = (head_slot + i) % CAPACITY;
      end
    end
    if (req == REQ_LOOKUP) begin
      res.status = found ? ST_HIT : ST_MISS;
      if (found) res.word = word_store[slot] & WORD_MASK;
    end else if (found) begin
      res.status = ST_PRESENT;
    end else begin
      res.status = ST_INSERTED;
      if (lim > 0) begin
        if (live_count >= lim) begin
          head_slot = (head_slot + 1) % CAPACITY;
          live_count--;
        end
        slot = (head_slot + live_count) % CAPACITY;
        key_store[slot]  = key;
        word_store[slot] = word & WORD_MASK;
        live_count++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                 input logic [WORD_BITS-1:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  task automatic add_probe(input logic req, input logic [KEY_BITS-1:0] key,
                           input logic [WORD_BITS-1:0] word, input bit fixed,
                           input status_e status, input logic [WORD_BITS-1:0] want);
    probe_t p;
    p.req        = req;
    p.key        = key;
    p.word       = word;
    p.fixed      = fixed;
    p.res.status = status;
    p.res.word   = want;
    probe_rows[probe_count] = p;
    probe_count++;
  endtask

  // Append one expected result behind the ones already waiting
  task automatic expect_result(input result_t res);
    pend_buf[pend_wr % PEND_DEPTH] = res;
    pend_wr++;
  endtask

  // Send one request beat after an optional random idle gap; record its result on acceptance
  task automatic send_request(input logic req, input logic [KEY_BITS-1:0] key,
                              input logic [WORD_BITS-1:0] word, input bit fixed,
                              input result_t fixed_res);
    int      gap;
    bit      drain;
    result_t res;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 25);
    end
    drain = ($urandom_range(0, 39) == 0);
    if (gap > 0 || drain) start_i <= 1'b0;
    // Hold off until every pending result has come back
    if (drain) begin
      do @(posedge clk_i); while (pending_count() != 0);
    end
    repeat (gap) @(posedge clk_i);
    start_i      <= 1'b1;
    req_type_i   <= req;
    key_i        <= key;
    payload_in_i <= word;
    do @(posedge clk_i); while (busy_o);
    res = lookup_or_insert(req, key, word);
    expect_result(fixed ? fixed_res : res);
  endtask

  // Write the limit once the cache has gone idle
  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    do @(posedge clk_i); while (pending_count() != 0 || busy_o);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= LIMIT_BITS'($urandom_range(0, 511));
    limit_reg = value;
  endtask

  // Run a random phase at one limit setting
  task automatic run_phase(input logic [LIMIT_BITS-1:0] value, input int beats,
                           input int insert_pct, input int fresh_pct);
    int                   span;
    logic                 req;
    logic [KEY_BITS-1:0]  key;
    result_t              unused;
    write_limit(value);
    span = 2 * live_limit() + 4;
    if (span > POOL_SIZE) span = POOL_SIZE;
    unused.status = ST_MISS;
    unused.word   = '0;
    for (int n = 0; n < beats; n++) begin
      req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_LOOKUP;
      if ($urandom_range(0, 99) < fresh_pct) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(0, span - 1)];
      send_request(req, key, {$urandom, $urandom}, 1'b0, unused);
    end
    start_i <= 1'b0;
  endtask

  // Check each result beat against the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_count() == 0) begin
        report_mismatch("result with nothing pending", {62'd0, status_o}, payload_out_o);
      end else begin
        oldest_want = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (status_o !== oldest_want.status)
          report_mismatch("status", {62'd0, status_o}, {62'd0, oldest_want.status});
        if (payload_out_o !== oldest_want.word)
          report_mismatch("payload", payload_out_o, oldest_want.word);
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    result_t fixed_res;
    mismatches   = 0;
    calm_left    = 0;
    head_slot    = 0;
    live_count   = 0;
    limit_reg    = LIMIT_RESET;
    key_pool[0]  = '0;
    key_pool[1]  = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    // Directed probes: extremes, repeats, ignored payload on lookup
    add_probe(REQ_LOOKUP, 64'd0, 64'd0, 1'b1, ST_MISS, 64'd0);
    add_probe(REQ_INSERT, 64'd0, '1, 1'b1, ST_INSERTED, 64'd0);
    add_probe(REQ_LOOKUP, 64'd0, 64'd0, 1'b1, ST_HIT, '1);
    add_probe(REQ_INSERT, 64'd0, 64'd0, 1'b1, ST_PRESENT, 64'd0);
    add_probe(REQ_LOOKUP, 64'd0, '1, 1'b1, ST_HIT, '1);
    add_probe(REQ_INSERT, '1, 64'd0, 1'b1, ST_INSERTED, 64'd0);
    add_probe(REQ_LOOKUP, '1, 64'd0, 1'b1, ST_HIT, 64'd0);
    add_probe(REQ_LOOKUP, 64'd1, 64'd0, 1'b1, ST_MISS, 64'd0);
    add_probe(REQ_INSERT, 64'h8000_0000_0000_0001, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, ST_MISS, 0);
    add_probe(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, ST_MISS, 0);
    add_probe(REQ_LOOKUP, 64'h8000_0000_0000_0001, 64'd0, 1'b0, ST_MISS, 0);
    add_probe(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE, '1, 1'b0, ST_MISS, 0);
    add_probe(REQ_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, 1'b0, ST_MISS, 0);
    add_probe(REQ_INSERT, 64'd1, 64'd1, 1'b0, ST_MISS, 0);
    add_probe(REQ_LOOKUP, 64'd1, 64'd0, 1'b0, ST_MISS, 0);
    add_probe(REQ_INSERT, 64'd1, '1, 1'b1, ST_PRESENT, 64'd0);
    add_probe(REQ_LOOKUP, 64'd1, 64'd0, 1'b0, ST_MISS, 0);
    add_probe(REQ_LOOKUP, '1, 64'd0, 1'b0, ST_MISS, 0);
    add_probe(REQ_INSERT, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, ST_MISS, 0);
    add_probe(REQ_LOOKUP, 64'hFFFF_FFFF_0000_0000, 64'd0, 1'b0, ST_MISS, 0);

    // Hold reset, then release it on a clock edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < probe_count; i++) begin
      fixed_res = probe_rows[i].res;
      send_request(probe_rows[i].req, probe_rows[i].key, probe_rows[i].word,
                   probe_rows[i].fixed, fixed_res);
    end
    start_i <= 1'b0;

    // Random phases: tiny, empty, saturated, full, shrinking and random limits
    run_phase(9'd1,   50, 50, 10);
    run_phase(9'd0,   30, 50, 10);
    run_phase(9'd511, 380, 75, 40);
    run_phase(9'd256, 120, 40, 10);
    run_phase(9'd3,   60, 50, 10);
    run_phase(9'd2,   50, 50, 10);
    run_phase(LIMIT_BITS'($urandom_range(1, 256)), 100, 50, 20);
    run_phase(LIMIT_BITS'($urandom_range(257, 511)), 60, 50, 20);
    run_phase(9'd16,  100, 50, 10);

    // Drain, then let a full scan pass for any stray beat
    while (pending_count() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
